@@ design/tmx_pkg.sv @@
// shared types and constants for the tree token mutex node
`default_nettype none

package tmx_pkg;

    localparam int ID_W       = 8;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;
    localparam int OBUF_LW    = 3;

    localparam logic [OP_W-1:0] OP_ENTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 3'd1;
    localparam logic [OP_W-1:0] OP_TOKEN   = 3'd2;
    localparam logic [OP_W-1:0] OP_LEAVE   = 3'd3;

    localparam logic KIND_PRIV = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT = 2'd1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] dest;
        logic            last;
    } t_msg;

endpackage

`default_nettype wire

@@ design/tmx_ram.sv @@
// single-port-write, single-port-read synchronous memory for the requester queue
`default_nettype none

module tmx_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/tmx_obuf.sv @@
// small output queue that takes up to two messages per cycle
`default_nettype none

module tmx_obuf (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr0,
    input  wire tmx_pkg::t_msg                 i_msg0,
    input  wire logic                          i_wr1,
    input  wire tmx_pkg::t_msg                 i_msg1,
    output logic                               o_valid,
    output tmx_pkg::t_msg                      o_msg,
    input  wire logic                          i_ready,
    output logic [tmx_pkg::OBUF_LW-1:0]        o_level
);

    tmx_pkg::t_msg                r_buf [tmx_pkg::OBUF_DEPTH];
    logic [tmx_pkg::OBUF_AW-1:0]  r_rd;
    logic [tmx_pkg::OBUF_AW-1:0]  r_wr;
    logic [tmx_pkg::OBUF_LW-1:0]  r_level;
    logic [tmx_pkg::OBUF_AW-1:0]  n_rd;
    logic [tmx_pkg::OBUF_AW-1:0]  n_wr;
    logic [tmx_pkg::OBUF_LW-1:0]  n_level;
    logic                         pop;

    assign o_valid = (r_level != '0);
    assign o_msg   = r_buf[r_rd];
    assign o_level = r_level;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_wr    = r_wr + tmx_pkg::OBUF_AW'(i_wr0) + tmx_pkg::OBUF_AW'(i_wr1);
        n_level = r_level + tmx_pkg::OBUF_LW'(i_wr0) + tmx_pkg::OBUF_LW'(i_wr1)
                  - tmx_pkg::OBUF_LW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_level <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_buf[r_wr] <= i_msg0;
        end
        if (i_wr1) begin
            r_buf[r_wr + 1'b1] <= i_msg1;
        end
    end

endmodule

`default_nettype wire

@@ design/tree_token_mutex_node_core.sv @@
// top level of one node of the tree-based token mutual exclusion scheme
`default_nettype none

// Each received message is handled in an apply step and a decision step: in the first the
// message is applied to the node state, a requester is written into the queue memory and the
// queue head is read; in the second the node decides whether to pass the token or grant its
// client and whether to ask its holder for the token. The queue memory has a registered read
// port, so a new message is not taken while a decision step is pending. Up to two outgoing
// messages per input go into a four-entry output queue, and the input stalls while fewer than
// two entries are free. The queue memory holds no reset value and needs no clearing after
// reset. Configuration writes are accepted in every cycle; writing parent_id loads the holder.
module tree_token_mutex_node_core #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_BITS     = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tmx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tmx_pkg::ID_W-1:0]        i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tmx_pkg::OP_W-1:0]        i_op,
    input  wire logic [tmx_pkg::ID_W-1:0]        i_sender_id,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_msg_kind,
    output logic [tmx_pkg::ID_W-1:0]             o_dest_id,
    output logic                                 o_last
);

    localparam int IW = (ID_BITS < tmx_pkg::ID_W) ? ID_BITS : tmx_pkg::ID_W;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [IW-1:0] r_self;
    logic [IW-1:0] r_holder;
    logic          r_in_use;
    logic          r_asked;
    logic [IW-1:0] r_client;
    logic [HW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_s2_valid;
    logic          r_fwd;
    logic [IW-1:0] r_fwd_data;

    logic [IW-1:0] n_self;
    logic [IW-1:0] n_holder;
    logic          n_in_use;
    logic          n_asked;
    logic [IW-1:0] n_client;
    logic [HW-1:0] n_head;
    logic [CW-1:0] n_count;

    logic          in_acc;
    logic          cfg_acc;
    logic [IW-1:0] sender;
    logic          push_en;
    logic [IW-1:0] push_id;
    logic          push_ok;
    logic [HW:0]   slot_sum;
    logic [HW-1:0] slot;
    logic [HW-1:0] head_inc;
    logic [IW-1:0] rd_data;
    logic [IW-1:0] head_id;
    logic          pop;
    logic          grant_self;
    logic [IW-1:0] holder_s2;
    logic          asked_s2;
    logic [CW-1:0] count_s2;
    logic          req;
    logic          wr0;
    logic          wr1;
    tmx_pkg::t_msg msg_priv;
    tmx_pkg::t_msg msg_req;
    tmx_pkg::t_msg msg0;
    tmx_pkg::t_msg out_msg;
    logic [tmx_pkg::OBUF_LW-1:0] obuf_level;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_s2_valid
                         && (obuf_level <= tmx_pkg::OBUF_LW'(tmx_pkg::OBUF_DEPTH - 2));
    assign in_acc      = i_in_valid && o_in_ready;
    assign sender      = i_sender_id[IW-1:0];

    // first cycle: apply the message, write the queue tail
    always_comb begin
        push_en = 1'b0;
        push_id = sender;
        unique case (i_op)
            tmx_pkg::OP_ENTER: begin
                push_en = 1'b1;
                push_id = r_self;
            end
            tmx_pkg::OP_REQUEST: begin
                push_en = 1'b1;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
        push_ok  = in_acc && push_en && (r_count < CW'(QUEUE_DEPTH));
        slot_sum = {1'b0, r_head} + {1'b0, r_count[HW-1:0]};
        if (slot_sum >= (HW+1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (HW+1)'(QUEUE_DEPTH);
        end
        slot     = slot_sum[HW-1:0];
        head_inc = (r_head == HW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    tmx_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (IW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (push_ok),
        .i_wr_addr (slot),
        .i_wr_data (push_id),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    // second cycle: pass or grant, then ask the holder
    always_comb begin
        head_id    = r_fwd ? r_fwd_data : rd_data;
        pop        = r_s2_valid && (r_holder == r_self) && !r_in_use && (r_count != '0);
        grant_self = pop && (head_id == r_self);
        holder_s2  = pop ? head_id : r_holder;
        asked_s2   = pop ? 1'b0 : r_asked;
        count_s2   = r_count - CW'(pop);
        req        = r_s2_valid && (holder_s2 != r_self) && (count_s2 != '0) && !asked_s2;

        msg_priv.kind = tmx_pkg::KIND_PRIV;
        msg_priv.dest = grant_self ? tmx_pkg::ID_W'(r_client) : tmx_pkg::ID_W'(head_id);
        msg_priv.last = !req;
        msg_req.kind  = tmx_pkg::KIND_REQ;
        msg_req.dest  = tmx_pkg::ID_W'(holder_s2);
        msg_req.last  = 1'b1;

        msg0 = pop ? msg_priv : msg_req;
        wr0  = pop || req;
        wr1  = pop && req;
    end

    always_comb begin
        n_self   = r_self;
        n_holder = r_holder;
        n_in_use = r_in_use;
        n_asked  = r_asked;
        n_client = r_client;
        n_head   = r_head;
        n_count  = r_count;
        if (in_acc) begin
            unique case (i_op)
                tmx_pkg::OP_ENTER: begin
                    n_client = sender;
                end
                tmx_pkg::OP_TOKEN: begin
                    n_holder = r_self;
                end
                tmx_pkg::OP_LEAVE: begin
                    n_in_use = 1'b0;
                    n_client = '0;
                end
                default: begin
                    n_client = r_client;
                end
            endcase
            if (push_ok) begin
                n_count = r_count + 1'b1;
            end
        end
        if (r_s2_valid) begin
            n_holder = holder_s2;
            n_in_use = r_in_use || grant_self;
            n_asked  = asked_s2 || req;
            n_count  = count_s2;
            if (pop) begin
                n_head = head_inc;
            end
        end
        if (cfg_acc) begin
            if (i_cfg_index == tmx_pkg::CFG_SELF) begin
                n_self = i_cfg_data[IW-1:0];
            end else if (i_cfg_index == tmx_pkg::CFG_PARENT) begin
                n_holder = i_cfg_data[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self     <= '0;
            r_holder   <= '0;
            r_in_use   <= 1'b0;
            r_asked    <= 1'b0;
            r_client   <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_self     <= n_self;
            r_holder   <= n_holder;
            r_in_use   <= n_in_use;
            r_asked    <= n_asked;
            r_client   <= n_client;
            r_head     <= n_head;
            r_count    <= n_count;
            r_s2_valid <= in_acc;
            r_fwd      <= push_ok && (r_count == '0);
        end
    end

    // bypass for a push into an empty queue
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= push_id;
        end
    end

    tmx_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (wr0),
        .i_msg0  (msg0),
        .i_wr1   (wr1),
        .i_msg1  (msg_req),
        .o_valid (o_out_valid),
        .o_msg   (out_msg),
        .i_ready (i_out_ready),
        .o_level (obuf_level)
    );

    assign o_msg_kind = out_msg.kind;
    assign o_dest_id  = out_msg.dest;
    assign o_last     = out_msg.last;

    a_s2_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s2_valid)
        else $error("decision cycle missing after accepted transaction");

    a_s2_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |=> !r_s2_valid)
        else $error("decision cycles overlap");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("request queue count exceeds depth");

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        obuf_level <= tmx_pkg::OBUF_LW'(tmx_pkg::OBUF_DEPTH))
        else $error("output queue overflow");

endmodule

`default_nettype wire
